// File: rtl/sfld_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the framed link deframer.
package sfld_pkg;

    // Field widths fixed by the link format
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Default frame length in words
    localparam int unsigned FRAME_WORDS_DEF = 16;

    // Command queue between front and back
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PW    = 2;

    // Input kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_LINK_ERR = 2'd2;

    // Result event codes
    localparam logic EV_WORD    = 1'b0;
    localparam logic EV_TIMEOUT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'd165;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'd90;
    localparam logic [BYTE_W-1:0] TIMEOUT_TICKS_RST = 8'd3;

    localparam logic [COUNT_W-1:0] IDLE_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] byte_value;
    } t_item;

    typedef struct packed {
        logic              event_res;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  word_index;
        logic              last;
        logic [COUNT_W-1:0] bytes_held;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] timeout_ticks;
    } t_cfg;

    typedef enum logic {
        CMD_WORD    = 1'b0,
        CMD_TIMEOUT = 1'b1
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic               frame_end;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  data;
        logic [COUNT_W-1:0] held;
    } t_cmd;

endpackage

// File: rtl/sfld_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sfld_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]      i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: rtl/sfld_front.sv
`timescale 1ns / 1ps
// Front end: sync hunt, byte packing and idle timeout, issuing store commands.
module sfld_front import sfld_pkg::*; #(
    parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  logic  i_full,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_cmd_push,
    output t_cmd  o_cmd
);

    localparam logic [COUNT_W-1:0] LAST_BYTE = COUNT_W'(4 * FRAME_WORDS - 1);

    typedef enum logic [1:0] {
        FS_HUNT0 = 2'd0,
        FS_HUNT1 = 2'd1,
        FS_READ  = 2'd2
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [COUNT_W-1:0]  r_byte_count, n_byte_count;
    logic [COUNT_W-1:0]  r_idle, n_idle;
    logic [23:0]         r_shift, n_shift;
    logic [COUNT_W-1:0]  idle_inc;
    logic                accept;
    logic [BYTE_W-1:0]   b;

    assign accept   = i_push && !i_full;
    assign b        = i_item.byte_value;
    assign idle_inc = (r_idle != IDLE_MAX) ? r_idle + 1'b1 : r_idle;

    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_idle       = r_idle;
        n_shift      = r_shift;
        o_cmd_push   = 1'b0;
        o_cmd        = '0;
        if (accept) begin
            case (i_item.kind)
                KIND_BYTE: begin
                    case (r_state)
                        FS_HUNT0: begin
                            if (b == i_cfg.sync_first) begin
                                n_state = FS_HUNT1;
                            end
                        end
                        FS_HUNT1: begin
                            if (b == i_cfg.sync_second) begin
                                n_state      = FS_READ;
                                n_byte_count = '0;
                                n_idle       = '0;
                            end else if (b != i_cfg.sync_first) begin
                                n_state = FS_HUNT0;
                            end
                        end
                        FS_READ: begin
                            n_idle       = '0;
                            n_shift      = {r_shift[15:0], b};
                            n_byte_count = r_byte_count + 1'b1;
                            if (r_byte_count[1:0] == 2'd3) begin
                                o_cmd_push      = 1'b1;
                                o_cmd.op        = CMD_WORD;
                                o_cmd.idx       = r_byte_count[COUNT_W-1:2];
                                o_cmd.data      = {r_shift, b};
                                o_cmd.frame_end = (r_byte_count == LAST_BYTE);
                            end
                            if (r_byte_count == LAST_BYTE) begin
                                n_state      = FS_HUNT0;
                                n_byte_count = '0;
                            end
                        end
                        default: begin
                            n_state      = FS_HUNT0;
                            n_byte_count = '0;
                            n_idle       = '0;
                        end
                    endcase
                end
                KIND_TICK: begin
                    if (r_state == FS_READ) begin
                        n_idle = idle_inc;
                        if (idle_inc > i_cfg.timeout_ticks) begin
                            o_cmd_push   = 1'b1;
                            o_cmd.op     = CMD_TIMEOUT;
                            o_cmd.held   = r_byte_count;
                            n_state      = FS_HUNT0;
                            n_byte_count = '0;
                            n_idle       = '0;
                        end
                    end
                end
                KIND_LINK_ERR: begin
                    n_state      = FS_HUNT0;
                    n_byte_count = '0;
                    n_idle       = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        if (!i_rst_n) begin
            r_state      <= FS_HUNT0;
            r_byte_count <= '0;
            r_idle       <= '0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_idle       <= n_idle;
        end
    end

endmodule

// File: rtl/sfld_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module sfld_cmd_fifo import sfld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_PW-1:0] r_wr_ptr;
    logic [CMD_PW-1:0] r_rd_ptr;
    logic [CMD_PW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (CMD_PW+1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/sfld_back.sv
`timescale 1ns / 1ps
// Back end: writes words to the store and plays out frames and timeouts.
module sfld_back import sfld_pkg::*; #(
    parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_ram_we,
    output logic [((FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1)-1:0] o_ram_waddr,
    output logic [WORD_W-1:0] o_ram_wdata,
    output logic [((FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1)-1:0] o_ram_raddr,
    input  logic [WORD_W-1:0] i_ram_rdata,
    input  logic              i_pop,
    output logic              o_valid,
    output t_result           o_result
);

    localparam int unsigned AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_WORDS - 1);

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_READ = 2'd1,
        B_WAIT = 2'd2
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic             out_free;

    assign out_free    = !r_out_valid || i_pop;
    assign o_ram_waddr = i_cmd.idx[AW-1:0];
    assign o_ram_wdata = i_cmd.data;
    assign o_ram_raddr = r_idx[AW-1:0];
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        o_ram_we    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == CMD_WORD) begin
                        o_cmd_pop = 1'b1;
                        o_ram_we  = 1'b1;
                        if (i_cmd.frame_end) begin
                            n_idx   = '0;
                            n_state = B_READ;
                        end
                    end else if (out_free) begin
                        o_cmd_pop        = 1'b1;
                        n_out_valid      = 1'b1;
                        n_out.event_res  = EV_TIMEOUT;
                        n_out.word       = '0;
                        n_out.word_index = '0;
                        n_out.last       = 1'b1;
                        n_out.bytes_held = i_cmd.held;
                    end
                end
            end
            B_READ: begin
                n_state = B_WAIT;
            end
            B_WAIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.event_res  = EV_WORD;
                    n_out.word       = i_ram_rdata;
                    n_out.word_index = r_idx;
                    n_out.last       = (r_idx == LAST_IDX);
                    n_out.bytes_held = '0;
                    if (r_idx == LAST_IDX) begin
                        n_state = B_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = B_READ;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/sync_framed_link_deframer_unit.sv
`timescale 1ns / 1ps
// Top level of the two-byte-sync fixed-length frame deframer.
//
// Link bytes, timer ticks and link-error events go in through a queue-style
// port (push/full); frame words and timeout notices come out through another
// (empty/pop). The front end takes one input transaction per clock while its
// command queue (4 entries) has room: it hunts for the sync pair, packs bytes
// big-endian into 32-bit words and tracks idle ticks. Each finished word goes
// through the queue to the back end, which writes it into a word RAM of
// FRAME_WORDS entries. When the last word of a frame lands, the back end
// plays the frame out word by word: a registered RAM read, then a load of
// the result register, which waits while an unpopped result is still held.
// During the burst the front end keeps taking input until the queue fills.
// A timeout notice is loaded into the result register from the idle state
// once that register is free. The word RAM needs no clearing pass: every
// word is written in full before it is read.
module sync_framed_link_deframer_unit import sfld_pkg::*; #(
    parameter int unsigned FRAME_WORDS = FRAME_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transactions
    input  logic                 push,
    output logic                 full,
    input  t_item                i_item,
    // result transactions
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_result,
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [BYTE_W-1:0]    i_cfg_wdata
);

    localparam int unsigned AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

    t_cfg              r_cfg;
    logic              cmd_push;
    t_cmd              cmd_in;
    logic              cmd_valid;
    t_cmd              cmd_out;
    logic              cmd_pop;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              res_valid;

    assign empty = !res_valid;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= SYNC_FIRST_RST;
            r_cfg.sync_second   <= SYNC_SECOND_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_SYNC_FIRST:    r_cfg.sync_first    <= i_cfg_wdata;
                CFG_SYNC_SECOND:   r_cfg.sync_second   <= i_cfg_wdata;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sfld_front #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Queue full is what stalls the input side
    sfld_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    sfld_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAME_WORDS)
    ) u_word_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    sfld_back #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_pop       (pop),
        .o_valid     (res_valid),
        .o_result    (o_result)
    );

    // The front end only issues a command on an accepted transaction
    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !full)
        else $error("command issued into a full queue");

    // Frame words carry last exactly on the final index
    a_word_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.event_res == EV_WORD)) |->
        (o_result.last == (o_result.word_index == IDX_W'(FRAME_WORDS - 1))))
        else $error("last flag does not match word index");

    // A timeout reports fewer bytes than a full frame and is marked last
    a_timeout_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.event_res == EV_TIMEOUT)) |->
        (o_result.last && (o_result.bytes_held < COUNT_W'(4 * FRAME_WORDS))))
        else $error("malformed timeout result");

endmodule
